@@ sv/vcf_pkg.sv @@
// Shared types and codes of the vertex curvature force unit.
`default_nettype none
package vcf_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		STATUS_APPLIED  = 2'd0,
		STATUS_ENDPOINT = 2'd1,
		STATUS_ZERO_LEN = 2'd2
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0] prev_px;
		logic [DATA_W-1:0] prev_py;
		logic [DATA_W-1:0] prev_pz;
		logic [DATA_W-1:0] here_px;
		logic [DATA_W-1:0] here_py;
		logic [DATA_W-1:0] here_pz;
		logic [DATA_W-1:0] next_px;
		logic [DATA_W-1:0] next_py;
		logic [DATA_W-1:0] next_pz;
		logic [DATA_W-1:0] field_mag;
		logic [DATA_W-1:0] min_len_in;
		logic              interior;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] curv_fx;
		logic [DATA_W-1:0] curv_fy;
		logic [DATA_W-1:0] curv_fz;
		logic [DATA_W-1:0] curv_norm;
		logic [DATA_W-1:0] min_len_out;
		status_t           status;
	} result_t;

endpackage
`default_nettype wire

@@ sv/vertex_curvature_force_unit.sv @@
// Top level of the vertex curvature force unit: stream ports, mode register, output skid.
`default_nettype none
// Computes the curvature force at one polyline vertex from the vertex, its two neighbors,
// the field magnitude and the running minimum segment length, all signed Q16.16 (the field
// magnitude unsigned). For an interior vertex the two segment unit vectors are formed, their
// difference is scaled by the field magnitude and by an inverse length chosen by mean_mode
// (0: mean of the two inverse lengths, 1: inverse of the mean length; reset value 1), and the
// force, its norm and the lowered minimum length come back with status 0. An endpoint gives
// status 1 and a zero-length segment status 2; both return zero force and norm and pass the
// minimum through. The unit takes one vertex per clock cycle while the skid entry is free; a
// vertex passes through the two 32-step root chains and the 33-step reciprocal divider, each
// retiring one bit per pipeline stage. A two-entry output stage lets the pipeline take one more
// vertex while a result waits; after that the whole pipeline holds.
// Write mean_mode only while no vertex is in flight.
module vertex_curvature_force_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Vertex input.
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// prev_px, prev_py, prev_pz, here_px, here_py, here_pz, next_px, next_py, next_pz,
	// field_mag, min_len_in: 32 bits each, from the lowest bit up.
	input  wire logic [351:0] s_tdata,
	// interior.
	input  wire logic [0:0]   s_tuser,
	// Result output.
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// curv_fx, curv_fy, curv_fz, curv_norm, min_len_out: 32 bits each, from the lowest bit up.
	output logic [159:0]      m_tdata,
	// status.
	output logic [1:0]        m_tuser,
	// Mode register write.
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [0:0]   cfg_data
);

	logic             mean_mode_q;
	vcf_pkg::item_t   item;
	logic             en;
	logic             pipe_valid;
	vcf_pkg::result_t pipe_res;
	logic             out_v_q, skid_v_q;
	vcf_pkg::result_t out_q, skid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			mean_mode_q <= cfg_data[0];
		end
	end

	always_comb begin
		item.prev_px    = s_tdata[31:0];
		item.prev_py    = s_tdata[63:32];
		item.prev_pz    = s_tdata[95:64];
		item.here_px    = s_tdata[127:96];
		item.here_py    = s_tdata[159:128];
		item.here_pz    = s_tdata[191:160];
		item.next_px    = s_tdata[223:192];
		item.next_py    = s_tdata[255:224];
		item.next_pz    = s_tdata[287:256];
		item.field_mag  = s_tdata[319:288];
		item.min_len_in = s_tdata[351:320];
		item.interior   = s_tuser[0];
	end

	// The pipeline advances whenever the skid entry is free, so the stall path is one flop.
	assign en       = !skid_v_q;
	assign s_tready = en;

	vcf_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_item   (item),
		.mean_mode (mean_mode_q),
		.out_valid (pipe_valid),
		.out_res   (pipe_res)
	);

	// Output register with one skid entry behind it. When the output is free the skid entry
	// drains first; otherwise a result leaving the pipeline parks in the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			out_v_q  <= skid_v_q || pipe_valid;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			skid_v_q <= pipe_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : pipe_res;
		end
		if (out_v_q && !m_tready && !skid_v_q) begin
			skid_q <= pipe_res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q.min_len_out, out_q.curv_norm, out_q.curv_fz, out_q.curv_fy,
	                   out_q.curv_fx};
	assign m_tuser  = out_q.status;

`ifndef SYNTHESIS
	a_skid_behind_out : assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> m_tvalid)
		else $error("skid entry holds a result while the output is empty");

	a_skid_fill_on_stall : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(m_tvalid && !m_tready))
		else $error("skid entry filled without a stalled output");

	a_skipped_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != 2'(vcf_pkg::STATUS_APPLIED)) |-> (m_tdata[127:0] == '0))
		else $error("skipped vertex carries a nonzero force or norm");

	a_no_take_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !m_tready) |=> (skid_v_q && $stable(skid_q)))
		else $error("parked result lost while the output stalled");
`endif

endmodule
`default_nettype wire

@@ sv/vcf_pipe.sv @@
// Arithmetic pipeline of the vertex curvature force unit: lengths, unit vectors, force and norm.
`default_nettype none
module vcf_pipe (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire vcf_pkg::item_t  in_item,
	input  wire logic            mean_mode,
	output logic                 out_valid,
	output vcf_pkg::result_t     out_res
);

	localparam int SQ_STEPS   = 32;
	localparam int UNIT_STEPS = 17;
	localparam int RCP_STEPS  = 33;
	localparam int LAT        = 4 + SQ_STEPS + 1 + RCP_STEPS + 7 + SQ_STEPS;

	typedef struct packed {
		vcf_pkg::status_t status;
		logic [31:0]      min_len;
		logic [31:0]      bmag;
	} side_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sqs_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [16:0] q;
	} uds_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [32:0] q;
	} rds_t;

	typedef struct packed {
		logic [5:0][30:0] ms;
		logic [1:0]       sh;
		logic [5:0]       neg;
		side_t            side;
	} fcar_t;

	typedef struct packed {
		logic [5:0] neg;
		side_t      side;
	} dcar_t;

	typedef struct packed {
		logic [2:0][31:0] force_v;
		side_t            side;
	} tcar_t;

	function automatic sqs_t sqrt_step(sqs_t a);
		logic [34:0] cur;
		logic [34:0] trial;
		sqs_t        r;
		cur   = {a.rem, a.rad[63:62]};
		trial = {1'b0, a.root, 2'b01};
		if (cur >= trial) begin
			r.rem  = 33'(cur - trial);
			r.root = {a.root[30:0], 1'b1};
		end else begin
			r.rem  = cur[32:0];
			r.root = {a.root[30:0], 1'b0};
		end
		r.rad = {a.rad[61:0], 2'b00};
		return r;
	endfunction

	function automatic uds_t unit_step(uds_t a, logic [32:0] cur, logic [31:0] d);
		uds_t r;
		if (cur >= {1'b0, d}) begin
			r.rem = 32'(cur - {1'b0, d});
			r.q   = {a.q[15:0], 1'b1};
		end else begin
			r.rem = cur[31:0];
			r.q   = {a.q[15:0], 1'b0};
		end
		return r;
	endfunction

	function automatic rds_t rcp_step(rds_t a, logic nbit, logic [33:0] d);
		logic [34:0] cur;
		rds_t        r;
		cur = {a.rem, nbit};
		if (cur >= {1'b0, d}) begin
			r.rem = 34'(cur - {1'b0, d});
			r.q   = {a.q[31:0], 1'b1};
		end else begin
			r.rem = cur[33:0];
			r.q   = {a.q[31:0], 1'b0};
		end
		return r;
	endfunction

	// Valid bits travel beside the data.
	logic [LAT:1] v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[LAT-1:1], in_valid};
		end
	end

	assign out_valid = v_s[LAT];

	// Stage 1: segment component differences.
	logic [5:0][31:0] from_c, to_c, mag_c;
	logic [5:0][32:0] diff_c;
	logic [5:0]       neg_c;
	side_t            side_c;

	always_comb begin
		from_c = {in_item.here_pz, in_item.here_py, in_item.here_px,
		          in_item.prev_pz, in_item.prev_py, in_item.prev_px};
		to_c   = {in_item.next_pz, in_item.next_py, in_item.next_px,
		          in_item.here_pz, in_item.here_py, in_item.here_px};
		for (int k = 0; k < 6; k++) begin
			diff_c[k] = {to_c[k][31], to_c[k]} - {from_c[k][31], from_c[k]};
			neg_c[k]  = diff_c[k][32];
			mag_c[k]  = neg_c[k] ? 32'(33'd0 - diff_c[k]) : diff_c[k][31:0];
		end
		side_c.bmag    = in_item.field_mag;
		side_c.min_len = in_item.min_len_in;
		if (!in_item.interior) begin
			side_c.status = vcf_pkg::STATUS_ENDPOINT;
		end else if ((mag_c[0] | mag_c[1] | mag_c[2]) == '0 ||
		             (mag_c[3] | mag_c[4] | mag_c[5]) == '0) begin
			side_c.status = vcf_pkg::STATUS_ZERO_LEN;
		end else begin
			side_c.status = vcf_pkg::STATUS_APPLIED;
		end
	end

	logic [5:0][31:0] mag_s1;
	logic [5:0]       neg_s1;
	side_t            side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_c;
			neg_s1  <= neg_c;
			side_s1 <= side_c;
		end
	end

	// Stage 2: bring every segment's components below 2^31.
	logic [1:0]       sh_c;
	logic [5:0][30:0] ms_c;

	always_comb begin
		sh_c[0] = mag_s1[0][31] | mag_s1[1][31] | mag_s1[2][31];
		sh_c[1] = mag_s1[3][31] | mag_s1[4][31] | mag_s1[5][31];
		for (int k = 0; k < 6; k++) begin
			ms_c[k] = sh_c[k/3] ? mag_s1[k][31:1] : mag_s1[k][30:0];
		end
	end

	fcar_t fcar_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			fcar_s2.ms   <= ms_c;
			fcar_s2.sh   <= sh_c;
			fcar_s2.neg  <= neg_s1;
			fcar_s2.side <= side_s1;
		end
	end

	// Stage 3: squares of the components.
	logic [5:0][61:0] sqr_s3;
	fcar_t            fcar_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 6; k++) begin
				sqr_s3[k] <= 62'(fcar_s2.ms[k]) * 62'(fcar_s2.ms[k]);
			end
			fcar_s3 <= fcar_s2;
		end
	end

	// Stage 4 and the segment root chain, one root bit per stage.
	sqs_t [1:0] sa_s [0:SQ_STEPS];
	fcar_t      fa_s [0:SQ_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 2; j++) begin
				sa_s[0][j].rem  <= '0;
				sa_s[0][j].root <= '0;
				sa_s[0][j].rad  <= 64'(sqr_s3[3*j]) + 64'(sqr_s3[3*j+1]) + 64'(sqr_s3[3*j+2]);
			end
			fa_s[0] <= fcar_s3;
		end
	end

	for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_seg_root
		always_ff @(posedge clk) begin
			if (en) begin
				sa_s[k][0] <= sqrt_step(sa_s[k-1][0]);
				sa_s[k][1] <= sqrt_step(sa_s[k-1][1]);
				fa_s[k]    <= fa_s[k-1];
			end
		end
	end

	// Length stage: lengths, minimum update, divider set-up.
	logic [1:0][32:0] len_c;
	logic [32:0]      shorter_c;
	logic [30:0]      cap_c;
	side_t            lside_c;
	logic [33:0]      div_a_c;

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			len_c[j] = fa_s[SQ_STEPS].sh[j] ? {sa_s[SQ_STEPS][j].root, 1'b0}
			                                : {1'b0, sa_s[SQ_STEPS][j].root};
		end
		shorter_c = (len_c[1] < len_c[0]) ? len_c[1] : len_c[0];
		cap_c     = (shorter_c > 33'h07FFF_FFFF) ? 31'h7FFF_FFFF : shorter_c[30:0];
		lside_c   = fa_s[SQ_STEPS].side;
		if (lside_c.status == vcf_pkg::STATUS_APPLIED &&
		    (lside_c.min_len[31] || lside_c.min_len > {1'b0, cap_c})) begin
			lside_c.min_len = {1'b0, cap_c};
		end
		div_a_c = mean_mode ? 34'(len_c[0]) + 34'(len_c[1]) : 34'(len_c[0]);
	end

	// Divider chains: unit components take 17 steps, reciprocals 33.
	uds_t [5:0]       du_s    [0:RCP_STEPS];
	logic [1:0][31:0] droot_s [0:RCP_STEPS];
	rds_t [1:0]       dr_s    [0:RCP_STEPS];
	logic [1:0][33:0] ddiv_s  [0:RCP_STEPS];
	dcar_t            dc_s    [0:RCP_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 6; k++) begin
				du_s[0][k].rem <= {1'b0, fa_s[SQ_STEPS].ms[k]};
				du_s[0][k].q   <= '0;
			end
			droot_s[0][0]  <= sa_s[SQ_STEPS][0].root;
			droot_s[0][1]  <= sa_s[SQ_STEPS][1].root;
			dr_s[0][0].rem <= mean_mode ? 34'd1 : 34'd0;
			dr_s[0][0].q   <= '0;
			dr_s[0][1].rem <= '0;
			dr_s[0][1].q   <= '0;
			ddiv_s[0][0]   <= div_a_c;
			ddiv_s[0][1]   <= 34'(len_c[1]);
			dc_s[0].neg    <= fa_s[SQ_STEPS].neg;
			dc_s[0].side   <= lside_c;
		end
	end

	for (genvar j = 1; j <= RCP_STEPS; j++) begin : g_div
		logic [5:0][32:0] cur_c;
		logic             nbit_a_c;
		logic             nbit_b_c;

		always_comb begin
			for (int k = 0; k < 6; k++) begin
				cur_c[k] = (j == 1) ? {1'b0, du_s[j-1][k].rem} : {du_s[j-1][k].rem, 1'b0};
			end
			nbit_a_c = (j == 1) ? !mean_mode : 1'b0;
			nbit_b_c = (j == 1);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 6; k++) begin
					if (j <= UNIT_STEPS) begin
						du_s[j][k] <= unit_step(du_s[j-1][k], cur_c[k], droot_s[j-1][k/3]);
					end else begin
						du_s[j][k] <= du_s[j-1][k];
					end
				end
				dr_s[j][0] <= rcp_step(dr_s[j-1][0], nbit_a_c, ddiv_s[j-1][0]);
				dr_s[j][1] <= rcp_step(dr_s[j-1][1], nbit_b_c, ddiv_s[j-1][1]);
				droot_s[j] <= droot_s[j-1];
				ddiv_s[j]  <= ddiv_s[j-1];
				dc_s[j]    <= dc_s[j-1];
			end
		end
	end

	// Stage 71: inverse length and unit-vector differences.
	logic [5:0][17:0] su_c;
	logic [2:0][18:0] c_c;
	logic [33:0]      rsum_c;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			su_c[k] = dc_s[RCP_STEPS].neg[k] ? 18'd0 - {1'b0, du_s[RCP_STEPS][k].q}
			                                 : {1'b0, du_s[RCP_STEPS][k].q};
		end
		for (int k = 0; k < 3; k++) begin
			c_c[k] = {su_c[k+3][17], su_c[k+3]} - {su_c[k][17], su_c[k]};
		end
		rsum_c = {1'b0, dr_s[RCP_STEPS][0].q} + {1'b0, dr_s[RCP_STEPS][1].q};
	end

	logic [32:0]      r_s71;
	logic [2:0][17:0] cm_s71;
	logic [2:0]       cneg_s71;
	side_t            side_s71;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s71 <= mean_mode ? dr_s[RCP_STEPS][0].q : rsum_c[33:1];
			for (int k = 0; k < 3; k++) begin
				cneg_s71[k] <= c_c[k][18];
				cm_s71[k]   <= c_c[k][18] ? 18'(19'd0 - c_c[k]) : c_c[k][17:0];
			end
			side_s71 <= dc_s[RCP_STEPS].side;
		end
	end

	// Stage 72: scale by the field magnitude.
	logic [2:0][33:0] p_s72;
	logic [32:0]      r_s72;
	logic [2:0]       cneg_s72;
	side_t            side_s72;
	logic [2:0][49:0] pb_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pb_c[k] = 50'(cm_s71[k]) * 50'(side_s71.bmag);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				p_s72[k] <= pb_c[k][49:16];
			end
			r_s72    <= r_s71;
			cneg_s72 <= cneg_s71;
			side_s72 <= side_s71;
		end
	end

	// Stage 73: partial products of the inverse-length scaling.
	logic [2:0][33:0] ll_s73, hl_s73;
	logic [2:0][32:0] lh_s73, hh_s73;
	logic [2:0]       cneg_s73;
	side_t            side_s73;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ll_s73[k] <= 34'(p_s72[k][16:0]) * 34'(r_s72[16:0]);
				lh_s73[k] <= 33'(p_s72[k][16:0]) * 33'(r_s72[32:17]);
				hl_s73[k] <= 34'(p_s72[k][33:17]) * 34'(r_s72[16:0]);
				hh_s73[k] <= 33'(p_s72[k][33:17]) * 33'(r_s72[32:17]);
			end
			cneg_s73 <= cneg_s72;
			side_s73 <= side_s72;
		end
	end

	// Stage 74: full product.
	logic [2:0][66:0] prod_s74;
	logic [2:0]       cneg_s74;
	side_t            side_s74;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				prod_s74[k] <= {hh_s73[k], 34'd0} + {17'd0, lh_s73[k], 17'd0}
				             + {16'd0, hl_s73[k], 17'd0} + {33'd0, ll_s73[k]};
			end
			cneg_s74 <= cneg_s73;
			side_s74 <= side_s73;
		end
	end

	// Stage 75: saturate, apply sign; skipped vertices give zero.
	logic [2:0][31:0] fm_c, lim_c;
	logic             applied_c;

	always_comb begin
		applied_c = (side_s74.status == vcf_pkg::STATUS_APPLIED);
		for (int k = 0; k < 3; k++) begin
			lim_c[k] = cneg_s74[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			if (!applied_c) begin
				fm_c[k] = '0;
			end else if (prod_s74[k][66:16] > 51'(lim_c[k])) begin
				fm_c[k] = lim_c[k];
			end else begin
				fm_c[k] = prod_s74[k][47:16];
			end
		end
	end

	logic [2:0][31:0] fm_s75;
	tcar_t            tc_s75;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				fm_s75[k]         <= fm_c[k];
				tc_s75.force_v[k] <= cneg_s74[k] ? 32'd0 - fm_c[k] : fm_c[k];
			end
			tc_s75.side <= side_s74;
		end
	end

	// Stage 76: squares of the force magnitudes.
	logic [2:0][63:0] sqf_s76;
	tcar_t            tc_s76;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sqf_s76[k] <= 64'(fm_s75[k]) * 64'(fm_s75[k]);
			end
			tc_s76 <= tc_s75;
		end
	end

	// Stage 77 and the norm root chain.
	sqs_t  sb_s [0:SQ_STEPS];
	tcar_t tb_s [0:SQ_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0].rem  <= '0;
			sb_s[0].root <= '0;
			sb_s[0].rad  <= sqf_s76[0] + sqf_s76[1] + sqf_s76[2];
			tb_s[0]      <= tc_s76;
		end
	end

	for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_norm_root
		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k] <= sqrt_step(sb_s[k-1]);
				tb_s[k] <= tb_s[k-1];
			end
		end
	end

	always_comb begin
		out_res.curv_fx     = tb_s[SQ_STEPS].force_v[0];
		out_res.curv_fy     = tb_s[SQ_STEPS].force_v[1];
		out_res.curv_fz     = tb_s[SQ_STEPS].force_v[2];
		out_res.curv_norm   = sb_s[SQ_STEPS].root;
		out_res.min_len_out = tb_s[SQ_STEPS].side.min_len;
		out_res.status      = tb_s[SQ_STEPS].side.status;
	end

endmodule
`default_nettype wire
